>>> design/cht_pkg.sv
// Shared types and constants for the cuckoo hash table.
// No dependencies.
`default_nettype none
package cht_pkg;
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int SALT_BYTES_DEF  = 5;
	localparam int KEY_BYTES_DEF   = 8;
	localparam int HASH_BASE       = 31;
	localparam int MAX_KICKS       = 100;
	localparam logic [39:0] SALT_ONE_RST = 40'h0101010101;
	localparam logic [39:0] SALT_TWO_RST = 40'h0202020202;
	localparam logic [6:0]  KICK_RST     = 7'd100;

	localparam logic [1:0] CFG_SALT_ONE = 2'd0;
	localparam logic [1:0] CFG_SALT_TWO = 2'd1;
	localparam logic [1:0] CFG_KICK     = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_DUP   = 2'd2;
	localparam logic [1:0] ST_LIMIT = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [63:0] key;
		logic [3:0]  len;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [63:0] ev_key;
		logic [3:0]  ev_len;
		logic [31:0] ev_value;
	} rsp_t;
endpackage
`default_nettype wire

>>> design/cht_front.sv
// Front end: normalizes key length and masks key bytes, holds a two-entry queue.
// Depends on cht_pkg.
`default_nettype none
module cht_front #(
	parameter int KEY_BYTES = cht_pkg::KEY_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic         kind,
	input  wire logic [63:0]  key_bytes,
	input  wire logic [3:0]   key_length,
	input  wire logic [31:0]  value_in,
	output logic              cmd_valid,
	input  wire logic         cmd_take,
	output cht_pkg::cmd_t     cmd
);
	localparam logic [3:0] KB = 4'(KEY_BYTES);
	cht_pkg::cmd_t q_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	cht_pkg::cmd_t norm;
	logic [3:0] len_n;
	logic [63:0] mask;

	always_comb begin
		len_n = key_length;
		if (len_n == 4'd0) len_n = 4'd1;
		if (len_n > KB) len_n = KB;
		mask = (len_n >= 4'd8) ? '1 : ((64'd1 << {len_n, 3'b000}) - 64'd1);
		norm.kind = kind;
		norm.key = key_bytes & mask;
		norm.len = len_n;
		norm.value = value_in;
	end

	assign full = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (cmd_take && cmd_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(cmd_take && cmd_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) q_q[wr_q] <= norm;
	end
endmodule
`default_nettype wire

>>> design/cht_back.sv
// Back end: serial hashing, table probes, eviction chain and result register.
// Depends on cht_pkg.
`default_nettype none
module cht_back #(
	parameter int TABLE_DEPTH = cht_pkg::TABLE_DEPTH_DEF,
	parameter int SALT_BYTES  = cht_pkg::SALT_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_take,
	input  wire cht_pkg::cmd_t cmd,
	input  wire logic [39:0]  salt_one,
	input  wire logic [39:0]  salt_two,
	input  wire logic [6:0]   kick_limit,
	output logic              empty,
	input  wire logic         pop,
	output cht_pkg::rsp_t     rsp
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int EW = 1 + 64 + 4 + 32;
	localparam int CW = $clog2(8 + SALT_BYTES + 1);
	localparam logic [CW-1:0] NSALT = CW'(SALT_BYTES);

	typedef enum logic [3:0] {
		CLR, IDLE, HASH, RD1, CHK1, RD2, CHK2, IHASH, IRD, IWR, DONE
	} state_t;
	state_t state_q;

	// Each entry is {used, key, length, value}; the used bit lives in the memory
	// and is cleared by a walk over all addresses after reset.
	logic [EW-1:0] mem1 [TABLE_DEPTH];
	logic [EW-1:0] mem2 [TABLE_DEPTH];
	logic [EW-1:0] rd1_q, rd2_q;
	logic [AW-1:0] clr_q;

	logic [AW-1:0] h_q, h1_q, h2_q;
	logic [CW-1:0] pos_q;
	logic tsel_q;      // 0 hashes table one, 1 table two
	logic kind_q, side_q;
	logic [63:0] ck_q;
	logic [3:0] cl_q;
	logic [31:0] cv_q;
	logic [6:0] kicks_q, lim;
	cht_pkg::rsp_t rsp_q;

	logic [7:0] byte_n;
	logic [39:0] salt;
	logic [AW+12:0] hmul;
	logic [EW-1:0] cur;
	logic [EW-1:0] rdsel;
	logic usel;
	logic hit1, hit2;
	cht_pkg::rsp_t rsp_chk;
	logic we1, we2, re1, re2;
	logic [AW-1:0] wa1, wa2;
	logic [EW-1:0] wd;

	function automatic logic hit(logic [EW-1:0] e, logic [63:0] k, logic [3:0] l);
		hit = e[EW-1] && (e[EW-2 -: 64] == k) && (e[35:32] == l);
	endfunction

	always_comb begin
		salt = tsel_q ? salt_two : salt_one;
		if (pos_q < CW'(cl_q))
			byte_n = 8'(ck_q >> {(cl_q - 4'd1 - 4'(pos_q)), 3'b000});
		else
			byte_n = 8'(salt >> {(NSALT - 1'b1 - (pos_q - CW'(cl_q))), 3'b000});
		hmul = (AW+13)'(h_q) * (AW+13)'(cht_pkg::HASH_BASE) + (AW+13)'(byte_n);
		lim = kick_limit;
		if (lim == 7'd0) lim = 7'd1;
		if (lim > 7'(cht_pkg::MAX_KICKS)) lim = 7'(cht_pkg::MAX_KICKS);
		cur = {1'b1, ck_q, cl_q, cv_q};
		rdsel = side_q ? rd2_q : rd1_q;
		usel = rdsel[EW-1];
		hit1 = hit(rd1_q, ck_q, cl_q);
		hit2 = hit(rd2_q, ck_q, cl_q);
		rsp_chk = '0;
		if (hit1 || hit2) begin
			if (kind_q) rsp_chk.status = cht_pkg::ST_DUP;
			else begin
				rsp_chk.status = cht_pkg::ST_OK;
				rsp_chk.value_out = hit1 ? rd1_q[31:0] : rd2_q[31:0];
			end
		end else begin
			rsp_chk.status = cht_pkg::ST_MISS;
		end
		we1 = (state_q == CLR) || ((state_q == IWR) && !side_q);
		we2 = (state_q == CLR) || ((state_q == IWR) && side_q);
		wa1 = (state_q == CLR) ? clr_q : h1_q;
		wa2 = (state_q == CLR) ? clr_q : h2_q;
		wd = (state_q == CLR) ? '0 : cur;
		re1 = (state_q == RD1) || ((state_q == IRD) && !side_q);
		re2 = (state_q == RD1) || ((state_q == IRD) && side_q);
	end

	assign empty = (state_q != DONE);
	assign rsp = rsp_q;
	assign cmd_take = (state_q == IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		if (we1) mem1[wa1] <= wd;
		if (we2) mem2[wa2] <= wd;
		if (re1) rd1_q <= mem1[h1_q];
		if (re2) rd2_q <= mem2[h2_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_DEPTH - 1)) state_q <= IDLE;
				end
				IDLE: if (cmd_valid) begin
					kind_q <= cmd.kind; ck_q <= cmd.key; cl_q <= cmd.len; cv_q <= cmd.value;
					h_q <= '0; pos_q <= '0; tsel_q <= 1'b0;
					state_q <= HASH;
				end
				HASH: begin
					if (pos_q == CW'(cl_q) + NSALT - 1'b1) begin
						pos_q <= '0; h_q <= '0;
						if (!tsel_q) begin
							h1_q <= AW'(hmul); tsel_q <= 1'b1;
						end else begin
							h2_q <= AW'(hmul); state_q <= RD1;
						end
					end else begin
						h_q <= AW'(hmul); pos_q <= pos_q + 1'b1;
					end
				end
				RD1: state_q <= CHK1;
				CHK1: begin
					if (hit1 || hit2 || !kind_q) begin
						rsp_q <= rsp_chk; state_q <= DONE;
					end else begin
						side_q <= 1'b0; kicks_q <= 7'd0; state_q <= IWR;
					end
				end
				IHASH: begin
					if (pos_q == CW'(cl_q) + NSALT - 1'b1) begin
						pos_q <= '0; h_q <= '0;
						if (!tsel_q) h1_q <= AW'(hmul); else h2_q <= AW'(hmul);
						state_q <= IRD;
					end else begin
						h_q <= AW'(hmul); pos_q <= pos_q + 1'b1;
					end
				end
				IRD: state_q <= IWR;
				IWR: begin
					if (!usel) begin
						rsp_q <= '0; state_q <= DONE;
					end else begin
						ck_q <= rdsel[EW-2 -: 64]; cl_q <= rdsel[35:32]; cv_q <= rdsel[31:0];
						if (kicks_q + 7'd1 == lim) begin
							rsp_q.status <= cht_pkg::ST_LIMIT; rsp_q.value_out <= '0;
							rsp_q.ev_key <= rdsel[EW-2 -: 64]; rsp_q.ev_len <= rdsel[35:32];
							rsp_q.ev_value <= rdsel[31:0];
							state_q <= DONE;
						end else begin
							kicks_q <= kicks_q + 7'd1; side_q <= ~side_q;
							tsel_q <= ~side_q; pos_q <= '0; h_q <= '0;
							state_q <= IHASH;
						end
					end
				end
				DONE: if (pop) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/cuckoo_hash_table.sv
// Top level of the cuckoo hash table: configuration registers and the two halves.
// Depends on cht_pkg, cht_front and cht_back.
//
// Use: beats enter on push/full. A two-entry queue in the front end takes
// beats while the back end works. Results appear on the result ports while
// empty is low and leave on pop; a stalled receiver holds the back end, and
// the front queue keeps filling until full rises.
// Hashing: each hash walks key and salt bytes one a cycle, once per table.
// A lookup hashes for table one, then table two, reads both tables, checks
// the entries and registers its result; the back end takes the next queued
// beat the cycle after the pop. An insert with no match writes its slot in
// table one, and each kick hashes the carried key, then reads and writes.
// The slot is the low bits of the hash, so TABLE_DEPTH must be a power of
// two; the block itself does not enforce it.
// Reset loads the salts and the kick limit with their defaults, then the back
// end walks all TABLE_DEPTH addresses to clear the used marks, one per cycle,
// before it takes the first beat. The configuration channel is always ready;
// writes are meant only while the block is idle.
`default_nettype none
module cuckoo_hash_table #(
	parameter int TABLE_DEPTH = cht_pkg::TABLE_DEPTH_DEF,
	parameter int SALT_BYTES  = cht_pkg::SALT_BYTES_DEF,
	parameter int KEY_BYTES   = cht_pkg::KEY_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              full,
	input  wire logic         kind,
	input  wire logic [63:0]  key_bytes,
	input  wire logic [3:0]   key_length,
	input  wire logic [31:0]  value_in,
	output logic              empty,
	input  wire logic         pop,
	output logic [1:0]        status,
	output logic [31:0]       value_out,
	output logic [63:0]       evicted_key,
	output logic [3:0]        evicted_length,
	output logic [31:0]       evicted_value,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [39:0]  cfg_data
);
	logic [39:0] salt_one_q, salt_two_q;
	logic [6:0] kick_q;
	logic cmd_valid, cmd_take;
	cht_pkg::cmd_t cmd;
	cht_pkg::rsp_t rsp;

	assign cfg_ready = 1'b1;

	// Salts are stored as full 40-bit words; the back end hashes their low SALT_BYTES bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_one_q <= cht_pkg::SALT_ONE_RST;
			salt_two_q <= cht_pkg::SALT_TWO_RST;
			kick_q <= cht_pkg::KICK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cht_pkg::CFG_SALT_ONE: salt_one_q <= cfg_data;
				cht_pkg::CFG_SALT_TWO: salt_two_q <= cfg_data;
				cht_pkg::CFG_KICK:     kick_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	cht_front #(.KEY_BYTES(KEY_BYTES)) u_front (
		.clk, .arst_n, .push, .full, .kind, .key_bytes, .key_length, .value_in,
		.cmd_valid, .cmd_take, .cmd
	);

	cht_back #(.TABLE_DEPTH(TABLE_DEPTH), .SALT_BYTES(SALT_BYTES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.salt_one(salt_one_q), .salt_two(salt_two_q), .kick_limit(kick_q),
		.empty, .pop, .rsp
	);

	assign status = rsp.status;
	assign value_out = rsp.value_out;
	assign evicted_key = rsp.ev_key;
	assign evicted_length = rsp.ev_len;
	assign evicted_value = rsp.ev_value;
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the cuckoo hash table: lookups, inserts, evictions and register writes.
// Depends on cht_pkg and cuckoo_hash_table; everything else is built in here.
`timescale 1ns / 100ps
module tb_top;
	localparam int DEPTH       = cht_pkg::TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 10000000;

	// One slot of the bench's own copy of a table.
	typedef struct {
		bit          used;
		logic [63:0] key;
		logic [3:0]  len;
		logic [31:0] value;
	} entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        kind = 1'b0;
	logic [63:0] key_bytes = '0;
	logic [3:0]  key_length = 4'd1;
	logic [31:0] value_in = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [31:0] value_out;
	logic [63:0] evicted_key;
	logic [3:0]  evicted_length;
	logic [31:0] evicted_value;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = cht_pkg::CFG_SALT_ONE;
	logic [39:0] cfg_data = '0;

	cuckoo_hash_table DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.kind(kind), .key_bytes(key_bytes), .key_length(key_length), .value_in(value_in),
		.empty(empty), .pop(pop), .status(status), .value_out(value_out),
		.evicted_key(evicted_key), .evicted_length(evicted_length),
		.evicted_value(evicted_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Mirror of the block's state and registers.
	entry_t      mirror_one [DEPTH];
	entry_t      mirror_two [DEPTH];
	logic [39:0] salt_a = cht_pkg::SALT_ONE_RST;
	logic [39:0] salt_b = cht_pkg::SALT_TWO_RST;
	logic [6:0]  kicks  = cht_pkg::KICK_RST;

	cht_pkg::rsp_t pending_rsp [$];
	logic [63:0] seen_keys [$];
	logic [3:0]  seen_lens [$];
	bit          idling = 1'b1;
	int          mismatches = 0;
	int          status_count [4] = '{0, 0, 0, 0};
	int          cycles = 0;
	int          hold = 0;

	function automatic int unsigned slot_of(logic [63:0] k, int len, logic [39:0] salt);
		int unsigned h;
		h = 0;
		for (int i = 0; i < len; i++)
			h = (h * cht_pkg::HASH_BASE + k[8 * (len - 1 - i) +: 8]) % DEPTH;
		for (int i = 0; i < cht_pkg::SALT_BYTES_DEF; i++)
			h = (h * cht_pkg::HASH_BASE
				+ salt[8 * (cht_pkg::SALT_BYTES_DEF - 1 - i) +: 8]) % DEPTH;
		return h;
	endfunction

	function automatic bit lookup_mirror(logic [63:0] k, logic [3:0] len,
			output logic [31:0] v);
		int unsigned s1, s2;
		s1 = slot_of(k, len, salt_a);
		s2 = slot_of(k, len, salt_b);
		v = '0;
		if (mirror_one[s1].used && mirror_one[s1].len == len && mirror_one[s1].key == k) begin
			v = mirror_one[s1].value;
			return 1'b1;
		end
		if (mirror_two[s2].used && mirror_two[s2].len == len && mirror_two[s2].key == k) begin
			v = mirror_two[s2].value;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Computes the result of one command and applies its effect to the mirror.
	function automatic cht_pkg::rsp_t table_outcome(cht_pkg::cmd_t c);
		cht_pkg::rsp_t r;
		logic [3:0]  len;
		logic [63:0] k;
		logic [31:0] v;
		int          limit;
		bit          in_one;
		int unsigned s;
		entry_t      carried, victim;
		r = '0;
		len = (c.len == 0) ? 4'd1 :
			(c.len > cht_pkg::KEY_BYTES_DEF) ? 4'(cht_pkg::KEY_BYTES_DEF) : c.len;
		k = (len >= 8) ? c.key : c.key & ((64'd1 << (8 * len)) - 1);
		if (!c.kind) begin
			if (lookup_mirror(k, len, v)) begin
				r.status = cht_pkg::ST_OK;
				r.value_out = v;
			end else
				r.status = cht_pkg::ST_MISS;
			return r;
		end
		if (lookup_mirror(k, len, v)) begin
			r.status = cht_pkg::ST_DUP;
			return r;
		end
		limit = (kicks == 0) ? 1 : (kicks > cht_pkg::MAX_KICKS) ? cht_pkg::MAX_KICKS : kicks;
		carried = '{1'b1, k, len, c.value};
		in_one = 1'b1;
		for (int i = 0; i < limit; i++) begin
			if (in_one) begin
				s = slot_of(carried.key, carried.len, salt_a);
				victim = mirror_one[s];
				mirror_one[s] = carried;
			end else begin
				s = slot_of(carried.key, carried.len, salt_b);
				victim = mirror_two[s];
				mirror_two[s] = carried;
			end
			if (!victim.used) begin
				r.status = cht_pkg::ST_OK;
				return r;
			end
			carried = victim;
			carried.used = 1'b1;
			in_one = !in_one;
		end
		r.status = cht_pkg::ST_LIMIT;
		r.ev_key = carried.key;
		r.ev_len = carried.len;
		r.ev_value = carried.value;
		return r;
	endfunction

	// Two-byte keys of one family share a polynomial hash, so they land on the same
	// slot in both tables whatever the salts are, which forces long eviction chains.
	function automatic logic [63:0] family_key(int fam, int member);
		logic [7:0] b0, b1;
		b0 = 8'(member);
		b1 = 8'(248 + fam - 31 * member);
		return {$urandom, 16'($urandom), b0, b1};
	endfunction

	// Sends one beat. Push stays high on return so that back-to-back items need no
	// second assignment in the same step; a gap or a drain lowers it.
	task automatic send_item(bit k, logic [63:0] kb, logic [3:0] len, logic [31:0] v);
		cht_pkg::cmd_t c;
		c = '{k, kb, len, v};
		kind <= k;
		key_bytes <= kb;
		key_length <= len;
		value_in <= v;
		push <= 1'b1;
		do @(posedge clk); while (full);
		pending_rsp.push_back(table_outcome(c));
		if (k && seen_keys.size() < 64) begin
			seen_keys.push_back(kb);
			seen_lens.push_back(len);
		end
		if (idling && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Holds the sender until every outstanding result has come back, then lets the
	// back end settle.
	task automatic drain();
		push <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			cht_pkg::CFG_SALT_ONE: salt_a = data;
			cht_pkg::CFG_SALT_TWO: salt_b = data;
			cht_pkg::CFG_KICK: kicks = data[6:0];
			default: ;
		endcase
	endtask

	task automatic test_basic_ops();
		send_item(1'b0, 64'h1234, 4'd2, 32'd0);                 // lookup in empty tables
		send_item(1'b1, '1, 4'd8, 32'h7fff_ffff);              // widest key
		send_item(1'b0, '1, 4'd8, 32'd0);
		send_item(1'b1, '1, 4'd8, 32'h1);                       // duplicate
		send_item(1'b1, 64'hdead_beef_cafe_0042, 4'd0, 32'h8000_0000); // length zero
		send_item(1'b0, 64'h0000_0000_0000_0042, 4'd1, 32'd0);  // same key, length one
		send_item(1'b1, 64'h0102_0304_0506_0708, 4'd15, 32'hffff_ffff); // saturating length
		send_item(1'b0, 64'h0102_0304_0506_0708, 4'd8, 32'd0);
		send_item(1'b1, 64'h0, 4'd3, 32'h5a5a_a5a5);           // all-zero key bytes
		send_item(1'b0, 64'h0, 4'd3, 32'd0);
		send_item(1'b0, 64'h0, 4'd4, 32'd0);                    // zero key, other length
	endtask

	task automatic test_kick_limits();
		write_reg(cht_pkg::CFG_KICK, 40'd1);
		send_item(1'b1, family_key(0, 0), 4'd2, 32'h11);
		send_item(1'b1, family_key(0, 1), 4'd2, 32'h22);       // limit on first swap
		send_item(1'b0, family_key(0, 0), 4'd2, 32'd0);
		write_reg(cht_pkg::CFG_KICK, 40'd0);
		send_item(1'b1, family_key(0, 2), 4'd2, 32'h33);
		write_reg(cht_pkg::CFG_KICK, 40'd100);
		send_item(1'b1, family_key(1, 0), 4'd2, 32'h44);
		send_item(1'b1, family_key(1, 1), 4'd2, 32'h55);
		send_item(1'b1, family_key(1, 2), 4'd2, 32'h66);       // chain runs to the limit
		write_reg(cht_pkg::CFG_KICK, 40'd127);
		send_item(1'b1, family_key(1, 3), 4'd2, 32'h77);
		send_item(1'b0, family_key(1, 1), 4'd2, 32'd0);
	endtask

	task automatic test_salt_extremes();
		write_reg(cht_pkg::CFG_SALT_ONE, 40'd0);
		write_reg(cht_pkg::CFG_SALT_TWO, 40'hff_ffff_ffff);
		send_item(1'b1, 64'h77, 4'd1, 32'h99);
		send_item(1'b0, 64'h77, 4'd1, 32'd0);
		send_item(1'b0, '1, 4'd8, 32'd0);
	endtask

	task automatic random_item();
		int          pick, idx;
		logic [63:0] kb;
		logic [3:0]  len;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			kb = family_key($urandom_range(0, 7), $urandom_range(0, 8));
			send_item($urandom_range(0, 1), kb, 4'd2, $urandom);
		end else if (pick < 75 && seen_keys.size() != 0) begin
			idx = $urandom_range(0, seen_keys.size() - 1);
			send_item($urandom_range(0, 1), seen_keys[idx], seen_lens[idx], $urandom);
		end else begin
			kb = {$urandom, $urandom};
			len = 4'($urandom_range(0, 15));
			send_item($urandom_range(0, 1), kb, len, $urandom);
		end
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(cht_pkg::CFG_SALT_ONE, {$urandom, 8'($urandom)});
			write_reg(cht_pkg::CFG_SALT_TWO, {$urandom, 8'($urandom)});
			write_reg(cht_pkg::CFG_KICK, (ph == 1) ? 40'd3 : 40'($urandom_range(0, 127)));
			idling = (ph != 3);
			for (int i = 0; i < 200; i++) begin
				random_item();
				if (ph == 2 && i == 100)
					drain();                                    // sender waits for a full drain
			end
		end
	endtask

	// Result side: checks every popped beat against the oldest expectation and
	// decides the next cycle's pop, stalling in random bursts while idling is on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat, status %0d", status);
				end else begin
					cht_pkg::rsp_t e;
					e = pending_rsp.pop_front();
					status_count[e.status]++;
					if (status !== e.status || value_out !== e.value_out ||
							evicted_key !== e.ev_key || evicted_length !== e.ev_len ||
							evicted_value !== e.ev_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp st=%0d val=%h ev=%h/%0d/%h",
								" got st=%0d val=%h ev=%h/%0d/%h"},
								e.status, e.value_out, e.ev_key, e.ev_len, e.ev_value,
								status, value_out, evicted_key, evicted_length,
								evicted_value);
					end
				end
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 17) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_kick_limits();
		test_salt_extremes();
		test_random_phases();
		drain();
		if (pending_rsp.size() != 0)
			mismatches++;
		$display({"Covered lookups, inserts, duplicates and eviction chains:",
			" %0d ok, %0d miss, %0d dup, %0d limit."},
			status_count[cht_pkg::ST_OK], status_count[cht_pkg::ST_MISS],
			status_count[cht_pkg::ST_DUP], status_count[cht_pkg::ST_LIMIT]);
		$display("Salts and kick limits were rewritten between phases; %0d mismatches.",
			mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
